FILE: rtl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types, codes and helper functions of the vending credit controller.
// ----------------------------------------------------------------------------
package vcc_pkg;

  // field widths fixed by the interface
  localparam int ACTION_W = 3;
  localparam int MONEY_W  = 16;
  localparam int OPTION_W = 5;
  localparam int COUNT_W  = 8;
  localparam int PRICE_W  = 16;
  localparam int MCODE_W  = 2;
  localparam int PROD_W   = 3;
  localparam int CFG_IDX_W = 3;

  // event codes
  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SELECT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REFUND   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RESTOCK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DISPENSE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_PLAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_SPICY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_CHOCOLATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_COCONUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_FRUITY    = 3'd4;

  // price reset values, pence
  localparam logic [PRICE_W-1:0] PRICE_PLAIN_RST     = 16'd100;
  localparam logic [PRICE_W-1:0] PRICE_SPICY_RST     = 16'd150;
  localparam logic [PRICE_W-1:0] PRICE_CHOCOLATE_RST = 16'd200;
  localparam logic [PRICE_W-1:0] PRICE_COCONUT_RST   = 16'd200;
  localparam logic [PRICE_W-1:0] PRICE_FRUITY_RST    = 16'd200;

  // product indexes, in code order
  localparam logic [PROD_W-1:0] PROD_NONE      = 3'd0;
  localparam logic [PROD_W-1:0] PROD_PLAIN     = 3'd1;
  localparam logic [PROD_W-1:0] PROD_SPICY     = 3'd2;
  localparam logic [PROD_W-1:0] PROD_CHOCOLATE = 3'd3;
  localparam logic [PROD_W-1:0] PROD_COCONUT   = 3'd4;
  localparam logic [PROD_W-1:0] PROD_FRUITY    = 3'd5;

  // one-hot product codes
  localparam logic [OPTION_W-1:0] CODE_NONE      = 5'b00000;
  localparam logic [OPTION_W-1:0] CODE_PLAIN     = 5'b00001;
  localparam logic [OPTION_W-1:0] CODE_SPICY     = 5'b00010;
  localparam logic [OPTION_W-1:0] CODE_CHOCOLATE = 5'b00100;
  localparam logic [OPTION_W-1:0] CODE_COCONUT   = 5'b01000;
  localparam logic [OPTION_W-1:0] CODE_FRUITY    = 5'b10000;

  // reported mode codes
  localparam logic [MCODE_W-1:0] MODE_CODE_EMPTY    = 2'd0;
  localparam logic [MCODE_W-1:0] MODE_CODE_NOCREDIT = 2'd1;
  localparam logic [MCODE_W-1:0] MODE_CODE_CREDIT   = 2'd2;
  localparam logic [MCODE_W-1:0] MODE_CODE_DISPENSE = 2'd3;

  // controller mode
  typedef enum logic [3:0] {
    MODE_EMPTY    = 4'b0001,
    MODE_NOCREDIT = 4'b0010,
    MODE_CREDIT   = 4'b0100,
    MODE_DISPENSE = 4'b1000
  } mode_t;

  // one result item
  typedef struct packed {
    logic                accepted;
    logic [MCODE_W-1:0]  mode_now;
    logic [MONEY_W-1:0]  credit_now;
    logic [COUNT_W-1:0]  stock_now;
    logic [MONEY_W-1:0]  refund_amount;
    logic [OPTION_W-1:0] dispensed_code;
    logic [MONEY_W-1:0]  shortfall;
  } result_t;

  function automatic logic [PROD_W-1:0] code_to_product(input logic [OPTION_W-1:0] code);
    logic [PROD_W-1:0] p;
    case (code)
      CODE_PLAIN:     p = PROD_PLAIN;
      CODE_SPICY:     p = PROD_SPICY;
      CODE_CHOCOLATE: p = PROD_CHOCOLATE;
      CODE_COCONUT:   p = PROD_COCONUT;
      CODE_FRUITY:    p = PROD_FRUITY;
      default:        p = PROD_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [OPTION_W-1:0] product_to_code(input logic [PROD_W-1:0] p);
    logic [OPTION_W-1:0] c;
    case (p)
      PROD_PLAIN:     c = CODE_PLAIN;
      PROD_SPICY:     c = CODE_SPICY;
      PROD_CHOCOLATE: c = CODE_CHOCOLATE;
      PROD_COCONUT:   c = CODE_COCONUT;
      PROD_FRUITY:    c = CODE_FRUITY;
      default:        c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [MCODE_W-1:0] mode_code(input mode_t m);
    logic [MCODE_W-1:0] c;
    case (m)
      MODE_EMPTY:    c = MODE_CODE_EMPTY;
      MODE_NOCREDIT: c = MODE_CODE_NOCREDIT;
      MODE_CREDIT:   c = MODE_CODE_CREDIT;
      MODE_DISPENSE: c = MODE_CODE_DISPENSE;
      default:       c = MODE_CODE_EMPTY;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/vcc_step.sv
// ----------------------------------------------------------------------------
// vcc_step
// Next-state and result logic for one event against the current state.
// ----------------------------------------------------------------------------
module vcc_step #(
  parameter int CREDIT_BITS = 16,
  parameter int STOCK_BITS  = 8
) (
  input  vcc_pkg::mode_t                  mode,
  input  logic [CREDIT_BITS-1:0]          credit,
  input  logic [STOCK_BITS-1:0]           stock,
  input  logic [vcc_pkg::PROD_W-1:0]      sel,
  input  logic [vcc_pkg::ACTION_W-1:0]    action,
  input  logic [vcc_pkg::MONEY_W-1:0]     money,
  input  logic [vcc_pkg::OPTION_W-1:0]    option,
  input  logic [vcc_pkg::COUNT_W-1:0]     stock_count,
  input  logic [vcc_pkg::PRICE_W-1:0]     price,
  output vcc_pkg::mode_t                  mode_next,
  output logic [CREDIT_BITS-1:0]          credit_next,
  output logic [STOCK_BITS-1:0]           stock_next,
  output logic [vcc_pkg::PROD_W-1:0]      sel_next,
  output vcc_pkg::result_t                result
);

  // working widths cover both the state and the fixed fields
  localparam int CW = (CREDIT_BITS > vcc_pkg::MONEY_W) ? CREDIT_BITS : vcc_pkg::MONEY_W;
  localparam int SW = (STOCK_BITS > vcc_pkg::COUNT_W) ? STOCK_BITS : vcc_pkg::COUNT_W;
  localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;
  localparam logic [STOCK_BITS-1:0]  STOCK_MAX  = '1;

  logic [CW-1:0]            money_w, credit_w, price_w, cmax_w, next_credit_w;
  logic [SW-1:0]            count_w, smax_w, next_stock_w;
  logic [CREDIT_BITS-1:0]   money_sat, credit_sub;
  logic [CREDIT_BITS:0]     credit_sum;
  logic [STOCK_BITS-1:0]    count_sat, stock_dec;
  logic [vcc_pkg::PROD_W-1:0] opt_prod;
  logic                     accepted;
  logic [vcc_pkg::MONEY_W-1:0]  refund_amount, shortfall;
  logic [vcc_pkg::OPTION_W-1:0] dispensed_code;

  // widened operands and saturated inputs
  assign money_w   = CW'(money);
  assign credit_w  = CW'(credit);
  assign price_w   = CW'(price);
  assign cmax_w    = CW'(CREDIT_MAX);
  assign count_w   = SW'(stock_count);
  assign smax_w    = SW'(STOCK_MAX);
  assign money_sat = (money_w > cmax_w) ? CREDIT_MAX : money_w[CREDIT_BITS-1:0];
  assign count_sat = (count_w > smax_w) ? STOCK_MAX : count_w[STOCK_BITS-1:0];

  // arithmetic used by the events
  assign credit_sum = {1'b0, credit} + {1'b0, money_sat};
  assign credit_sub = (credit_w >= price_w) ? CREDIT_BITS'(credit_w - price_w) : '0;
  assign stock_dec  = (stock != '0) ? stock - 1'b1 : '0;
  assign opt_prod   = vcc_pkg::code_to_product(option);

  // event decode
  always_comb begin
    mode_next      = mode;
    credit_next    = credit;
    stock_next     = stock;
    sel_next       = sel;
    accepted       = 1'b0;
    refund_amount  = '0;
    dispensed_code = '0;
    shortfall      = '0;
    case (action)
      vcc_pkg::ACT_INSERT: begin
        if (mode == vcc_pkg::MODE_NOCREDIT) begin
          credit_next = money_sat;
          mode_next   = vcc_pkg::MODE_CREDIT;
          accepted    = 1'b1;
        end else if (mode == vcc_pkg::MODE_CREDIT) begin
          credit_next = credit_sum[CREDIT_BITS] ? CREDIT_MAX : credit_sum[CREDIT_BITS-1:0];
          accepted    = 1'b1;
        end
      end
      vcc_pkg::ACT_SELECT: begin
        if (mode == vcc_pkg::MODE_CREDIT && opt_prod != vcc_pkg::PROD_NONE) begin
          if (price_w <= credit_w) begin
            sel_next  = opt_prod;
            mode_next = vcc_pkg::MODE_DISPENSE;
            accepted  = 1'b1;
          end else begin
            shortfall = vcc_pkg::MONEY_W'(price_w - credit_w);
          end
        end
      end
      vcc_pkg::ACT_REFUND: begin
        if (mode == vcc_pkg::MODE_EMPTY || mode == vcc_pkg::MODE_CREDIT) begin
          refund_amount = vcc_pkg::MONEY_W'(credit_w);
          credit_next   = '0;
          if (mode == vcc_pkg::MODE_CREDIT) begin
            mode_next = vcc_pkg::MODE_NOCREDIT;
          end
          accepted = 1'b1;
        end
      end
      vcc_pkg::ACT_RESTOCK: begin
        if (mode == vcc_pkg::MODE_EMPTY && stock_count != '0) begin
          stock_next = count_sat;
          mode_next  = vcc_pkg::MODE_NOCREDIT;
          accepted   = 1'b1;
        end
      end
      vcc_pkg::ACT_DISPENSE: begin
        if (mode == vcc_pkg::MODE_DISPENSE) begin
          stock_next     = stock_dec;
          credit_next    = credit_sub;
          dispensed_code = vcc_pkg::product_to_code(sel);
          if (stock_dec == '0) begin
            mode_next = vcc_pkg::MODE_EMPTY;
          end else if (credit_sub == '0) begin
            mode_next = vcc_pkg::MODE_NOCREDIT;
          end else begin
            mode_next = vcc_pkg::MODE_CREDIT;
          end
          accepted = 1'b1;
        end
      end
      default: begin
        // undefined events are refused
        accepted = 1'b0;
      end
    endcase
  end

  // result item, low bits of the state after the event
  assign next_credit_w = CW'(credit_next);
  assign next_stock_w  = SW'(stock_next);

  always_comb begin
    result.accepted       = accepted;
    result.mode_now       = vcc_pkg::mode_code(mode_next);
    result.credit_now     = next_credit_w[vcc_pkg::MONEY_W-1:0];
    result.stock_now      = next_stock_w[vcc_pkg::COUNT_W-1:0];
    result.refund_amount  = refund_amount;
    result.dispensed_code = dispensed_code;
    result.shortfall      = shortfall;
  end

endmodule

FILE: rtl/vcc_out_buf.sv
// ----------------------------------------------------------------------------
// vcc_out_buf
// Two-entry result buffer: an output register with a skid stage behind it.
// ----------------------------------------------------------------------------
module vcc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vcc_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output vcc_pkg::result_t out_data
);

  logic             main_valid;
  logic             skid_valid;
  vcc_pkg::result_t main_data;
  vcc_pkg::result_t skid_data;

  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      main_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_valid && !out_ready) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      main_data <= skid_data;
    end else if (push) begin
      main_data <= push_data;
    end
  end

endmodule

FILE: rtl/vending_credit_controller_core.sv
// ----------------------------------------------------------------------------
// vending_credit_controller_core
// Four-mode vending controller handling one event per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event: action, money,
//   option and stock_count. Output channel (out_valid/out_ready) returns one
//   result per event: accepted flag, mode, credit, stock, refund, dispensed
//   code and shortfall. The config port writes one price register per cycle
//   when cfg_we is high; cfg_index selects the register, cfg_data the value.
//   A result is registered, in the skid stage if a result already waits.
//   Throughput: one item per cycle while in_ready is high; the state update
//   is a single pass of compare, add/subtract and mode select in vcc_step.
//   A stalled receiver is absorbed by a skid stage: one more item is taken
//   while a result waits, then in_ready drops until the waiting result is
//   taken, and rises again the cycle after.
//   Reset (rst, synchronous): mode out of stock, credit and stock zero, no
//   product selected, prices back to defaults, output buffer empty.
// ----------------------------------------------------------------------------
module vending_credit_controller_core #(
  parameter int CREDIT_BITS = 16,
  parameter int STOCK_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vcc_pkg::PRICE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vcc_pkg::ACTION_W-1:0]    action,
  input  logic [vcc_pkg::MONEY_W-1:0]     money,
  input  logic [vcc_pkg::OPTION_W-1:0]    option,
  input  logic [vcc_pkg::COUNT_W-1:0]     stock_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [vcc_pkg::MCODE_W-1:0]     mode_now,
  output logic [vcc_pkg::MONEY_W-1:0]     credit_now,
  output logic [vcc_pkg::COUNT_W-1:0]     stock_now,
  output logic [vcc_pkg::MONEY_W-1:0]     refund_amount,
  output logic [vcc_pkg::OPTION_W-1:0]    dispensed_code,
  output logic [vcc_pkg::MONEY_W-1:0]     shortfall
);

  logic [vcc_pkg::PRICE_W-1:0] price_plain, price_spicy, price_chocolate;
  logic [vcc_pkg::PRICE_W-1:0] price_coconut, price_fruity, price;

  vcc_pkg::mode_t             mode, mode_next;
  logic [CREDIT_BITS-1:0]     credit, credit_next;
  logic [STOCK_BITS-1:0]      stock, stock_next;
  logic [vcc_pkg::PROD_W-1:0] sel, sel_next, price_prod;
  logic                       push;
  vcc_pkg::result_t           step_result, out_data;

  assign push = in_valid && in_ready;

  // price registers
  always_ff @(posedge clk) begin
    if (rst) begin
      price_plain     <= vcc_pkg::PRICE_PLAIN_RST;
      price_spicy     <= vcc_pkg::PRICE_SPICY_RST;
      price_chocolate <= vcc_pkg::PRICE_CHOCOLATE_RST;
      price_coconut   <= vcc_pkg::PRICE_COCONUT_RST;
      price_fruity    <= vcc_pkg::PRICE_FRUITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vcc_pkg::REG_PRICE_PLAIN:     price_plain     <= cfg_data;
        vcc_pkg::REG_PRICE_SPICY:     price_spicy     <= cfg_data;
        vcc_pkg::REG_PRICE_CHOCOLATE: price_chocolate <= cfg_data;
        vcc_pkg::REG_PRICE_COCONUT:   price_coconut   <= cfg_data;
        vcc_pkg::REG_PRICE_FRUITY:    price_fruity    <= cfg_data;
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // price lookup: the chosen option on select, the held product otherwise
  assign price_prod = (action == vcc_pkg::ACT_SELECT) ? vcc_pkg::code_to_product(option) : sel;

  always_comb begin
    case (price_prod)
      vcc_pkg::PROD_PLAIN:     price = price_plain;
      vcc_pkg::PROD_SPICY:     price = price_spicy;
      vcc_pkg::PROD_CHOCOLATE: price = price_chocolate;
      vcc_pkg::PROD_COCONUT:   price = price_coconut;
      vcc_pkg::PROD_FRUITY:    price = price_fruity;
      default:                 price = '0;
    endcase
  end

  // event logic
  vcc_step #(
    .CREDIT_BITS (CREDIT_BITS),
    .STOCK_BITS  (STOCK_BITS)
  ) u_step (
    .mode        (mode),
    .credit      (credit),
    .stock       (stock),
    .sel         (sel),
    .action      (action),
    .money       (money),
    .option      (option),
    .stock_count (stock_count),
    .price       (price),
    .mode_next   (mode_next),
    .credit_next (credit_next),
    .stock_next  (stock_next),
    .sel_next    (sel_next),
    .result      (step_result)
  );

  // controller state, updated once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= vcc_pkg::MODE_EMPTY;
      credit <= '0;
      stock  <= '0;
      sel    <= vcc_pkg::PROD_NONE;
    end else if (push) begin
      mode   <= mode_next;
      credit <= credit_next;
      stock  <= stock_next;
      sel    <= sel_next;
    end
  end

  // result buffer
  vcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (step_result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign accepted       = out_data.accepted;
  assign mode_now       = out_data.mode_now;
  assign credit_now     = out_data.credit_now;
  assign stock_now      = out_data.stock_now;
  assign refund_amount  = out_data.refund_amount;
  assign dispensed_code = out_data.dispensed_code;
  assign shortfall      = out_data.shortfall;

endmodule

FILE: rtl/vcc_checker.sv
// ----------------------------------------------------------------------------
// vcc_checker
// Port-level checks of the vending credit controller, bound to the top level.
// ----------------------------------------------------------------------------
module vcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          accepted,
  input logic [vcc_pkg::MCODE_W-1:0]   mode_now,
  input logic [vcc_pkg::MONEY_W-1:0]   credit_now,
  input logic [vcc_pkg::COUNT_W-1:0]   stock_now,
  input logic [vcc_pkg::MONEY_W-1:0]   refund_amount,
  input logic [vcc_pkg::OPTION_W-1:0]  dispensed_code,
  input logic [vcc_pkg::MONEY_W-1:0]   shortfall
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(credit_now) && $stable(stock_now)
      && $stable(mode_now) && $stable(accepted))
    else $error("result changed while stalled");

  // output buffer is empty on the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("result valid after reset");

  // input is only held off while a result waits
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // a dispensed code belongs to an accepted dispense that left dispensing mode
  a_dispense_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispensed_code != '0 |->
      accepted && $onehot(dispensed_code) && mode_now != vcc_pkg::MODE_CODE_DISPENSE)
    else $error("bad dispense result");

  // a shortfall only comes with a refused selection in has-credit mode
  a_shortfall_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && shortfall != '0 |->
      !accepted && mode_now == vcc_pkg::MODE_CODE_CREDIT && refund_amount == '0)
    else $error("shortfall on a non-refused selection");

endmodule

bind vending_credit_controller_core vcc_checker u_vcc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .accepted       (accepted),
  .mode_now       (mode_now),
  .credit_now     (credit_now),
  .stock_now      (stock_now),
  .refund_amount  (refund_amount),
  .dispensed_code (dispensed_code),
  .shortfall      (shortfall)
);
